/* src/segment_projection_overlap_macros.svh */
// Assertion macros for the segment projection overlap RTL.
`ifndef SEGMENT_PROJECTION_OVERLAP_MACROS_SVH
`define SEGMENT_PROJECTION_OVERLAP_MACROS_SVH
`ifndef SYNTHESIS
`define SPO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SPO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SPO_ASSERT(label, prop, msg)
`define SPO_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

/* src/spo_pkg.sv */
// Package with widths, payload types and stage types of the segment projection overlap block.
package spo_pkg;
    localparam int COORD_WIDTH     = 16;
    localparam int COORD_FRAC_BITS = 4;
    localparam int RATIO_FRAC_BITS = 15;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
    localparam int ACC_WIDTH       = PROD_WIDTH + 1;
    localparam int RATIO_WIDTH     = RATIO_FRAC_BITS + 1;
    localparam int DIV_STEPS       = RATIO_FRAC_BITS + 2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] obs_start_x;
        logic signed [COORD_WIDTH-1:0] obs_start_y;
        logic signed [COORD_WIDTH-1:0] obs_end_x;
        logic signed [COORD_WIDTH-1:0] obs_end_y;
        logic signed [COORD_WIDTH-1:0] proj_start_x;
        logic signed [COORD_WIDTH-1:0] proj_start_y;
        logic signed [COORD_WIDTH-1:0] proj_end_x;
        logic signed [COORD_WIDTH-1:0] proj_end_y;
    } seg_item_t;

    typedef struct packed {
        logic [RATIO_WIDTH-1:0] overlap_ratio;
        logic                   degenerate;
    } res_item_t;

    typedef enum logic [1:0] {
        MODE_VERT,
        MODE_HORZ,
        MODE_FOOT,
        MODE_DEGEN
    } mode_t;

    typedef struct packed {
        mode_t                        mode;
        logic signed [DIFF_WIDTH-1:0] dx;
        logic signed [DIFF_WIDTH-1:0] dy;
        logic signed [DIFF_WIDTH-1:0] psx;
        logic signed [DIFF_WIDTH-1:0] psy;
        logic signed [DIFF_WIDTH-1:0] qsx;
        logic signed [DIFF_WIDTH-1:0] qsy;
    } diff_t;

    typedef struct packed {
        diff_t                        diff;
        logic signed [PROD_WIDTH-1:0] pdx;
        logic signed [PROD_WIDTH-1:0] pdy;
        logic signed [PROD_WIDTH-1:0] qdx;
        logic signed [PROD_WIDTH-1:0] qdy;
        logic signed [PROD_WIDTH-1:0] ddx;
        logic signed [PROD_WIDTH-1:0] ddy;
    } prod_t;

    typedef struct packed {
        logic                 degen;
        logic [ACC_WIDTH-1:0] num;
        logic [ACC_WIDTH-1:0] den;
    } frac_t;
endpackage

/* src/spo_front.sv */
// Difference stage and product stage: direction, offsets, case choice and the six products.
module spo_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  spo_pkg::seg_item_t in_data,
    output logic               out_valid,
    output spo_pkg::prod_t     out_data
);
    import spo_pkg::*;

    localparam logic signed [DIFF_WIDTH-1:0] PIX_ONE = DIFF_WIDTH'(1 << COORD_FRAC_BITS);

    logic  v1_reg, v2_reg;
    diff_t d1_reg, d1_next;
    prod_t p2_reg, p2_next;
    logic  small_x, small_y;

    always_comb
    begin
        d1_next.dx  = DIFF_WIDTH'(in_data.obs_end_x) - DIFF_WIDTH'(in_data.obs_start_x);
        d1_next.dy  = DIFF_WIDTH'(in_data.obs_end_y) - DIFF_WIDTH'(in_data.obs_start_y);
        d1_next.psx = DIFF_WIDTH'(in_data.proj_start_x) - DIFF_WIDTH'(in_data.obs_start_x);
        d1_next.psy = DIFF_WIDTH'(in_data.proj_start_y) - DIFF_WIDTH'(in_data.obs_start_y);
        d1_next.qsx = DIFF_WIDTH'(in_data.proj_end_x) - DIFF_WIDTH'(in_data.obs_start_x);
        d1_next.qsy = DIFF_WIDTH'(in_data.proj_end_y) - DIFF_WIDTH'(in_data.obs_start_y);
        small_x = (d1_next.dx > -PIX_ONE) && (d1_next.dx < PIX_ONE);
        small_y = (d1_next.dy > -PIX_ONE) && (d1_next.dy < PIX_ONE);
        if (small_x)
        begin
            d1_next.mode = (d1_next.dy == '0) ? MODE_DEGEN : MODE_VERT;
        end
        else if (small_y)
        begin
            d1_next.mode = MODE_HORZ;
        end
        else
        begin
            d1_next.mode = MODE_FOOT;
        end
    end

    always_comb
    begin
        p2_next.diff = d1_reg;
        p2_next.pdx  = PROD_WIDTH'(d1_reg.psx) * PROD_WIDTH'(d1_reg.dx);
        p2_next.pdy  = PROD_WIDTH'(d1_reg.psy) * PROD_WIDTH'(d1_reg.dy);
        p2_next.qdx  = PROD_WIDTH'(d1_reg.qsx) * PROD_WIDTH'(d1_reg.dx);
        p2_next.qdy  = PROD_WIDTH'(d1_reg.qsy) * PROD_WIDTH'(d1_reg.dy);
        p2_next.ddx  = PROD_WIDTH'(d1_reg.dx) * PROD_WIDTH'(d1_reg.dx);
        p2_next.ddy  = PROD_WIDTH'(d1_reg.dy) * PROD_WIDTH'(d1_reg.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg <= d1_next;
            p2_reg <= p2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = p2_reg;
endmodule

/* src/spo_norm.sv */
// Sum stage and clip stage: lambda numerators over a positive denominator, ordered and clipped.
module spo_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  spo_pkg::prod_t in_data,
    output logic           out_valid,
    output spo_pkg::frac_t out_data
);
    import spo_pkg::*;

    logic                        v3_reg, v4_reg;
    logic signed [ACC_WIDTH-1:0] n0_reg, n1_reg, dn_reg;
    logic signed [ACC_WIDTH-1:0] n0_next, n1_next, dn_next;
    logic                        dg_reg, dg_next;
    frac_t                       f4_reg, f4_next;
    logic signed [ACC_WIDTH-1:0] lo, hi, lo_c, hi_c;

    always_comb
    begin
        dg_next = 1'b0;
        case (in_data.diff.mode)
            MODE_VERT:
            begin
                if (in_data.diff.dy < 0)
                begin
                    n0_next = -ACC_WIDTH'(in_data.diff.psy);
                    n1_next = -ACC_WIDTH'(in_data.diff.qsy);
                    dn_next = -ACC_WIDTH'(in_data.diff.dy);
                end
                else
                begin
                    n0_next = ACC_WIDTH'(in_data.diff.psy);
                    n1_next = ACC_WIDTH'(in_data.diff.qsy);
                    dn_next = ACC_WIDTH'(in_data.diff.dy);
                end
            end
            MODE_HORZ:
            begin
                if (in_data.diff.dx < 0)
                begin
                    n0_next = -ACC_WIDTH'(in_data.diff.psx);
                    n1_next = -ACC_WIDTH'(in_data.diff.qsx);
                    dn_next = -ACC_WIDTH'(in_data.diff.dx);
                end
                else
                begin
                    n0_next = ACC_WIDTH'(in_data.diff.psx);
                    n1_next = ACC_WIDTH'(in_data.diff.qsx);
                    dn_next = ACC_WIDTH'(in_data.diff.dx);
                end
            end
            MODE_FOOT:
            begin
                n0_next = ACC_WIDTH'(in_data.pdx) + ACC_WIDTH'(in_data.pdy);
                n1_next = ACC_WIDTH'(in_data.qdx) + ACC_WIDTH'(in_data.qdy);
                dn_next = ACC_WIDTH'(in_data.ddx) + ACC_WIDTH'(in_data.ddy);
            end
            default:
            begin
                n0_next = '0;
                n1_next = '0;
                dn_next = ACC_WIDTH'(1);
                dg_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (n1_reg < n0_reg)
        begin
            lo = n1_reg;
            hi = n0_reg;
        end
        else
        begin
            lo = n0_reg;
            hi = n1_reg;
        end
        lo_c = (lo < 0) ? '0 : ((dn_reg < lo) ? dn_reg : lo);
        hi_c = (hi < 0) ? '0 : ((dn_reg < hi) ? dn_reg : hi);
        f4_next.degen = dg_reg;
        f4_next.num   = ACC_WIDTH'(hi_c - lo_c);
        f4_next.den   = ACC_WIDTH'(dn_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n0_reg <= n0_next;
            n1_reg <= n1_next;
            dn_reg <= dn_next;
            dg_reg <= dg_next;
            f4_reg <= f4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = f4_reg;
endmodule

/* src/spo_div.sv */
// Pipelined restoring divider: one quotient bit per stage, last stage rounds half up.
module spo_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  spo_pkg::frac_t in_data,
    output logic           out_valid,
    output spo_pkg::res_item_t out_data
);
    import spo_pkg::*;

    logic [DIV_STEPS-1:0]   v_reg;
    logic [ACC_WIDTH-1:0]   rem_reg [DIV_STEPS];
    logic [ACC_WIDTH-1:0]   den_reg [DIV_STEPS];
    logic [RATIO_WIDTH-1:0] q_reg   [DIV_STEPS];
    logic [DIV_STEPS-1:0]   dg_reg;

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_step
            logic [ACC_WIDTH:0]     trial;
            logic [ACC_WIDTH-1:0]   den_in;
            logic [RATIO_WIDTH-1:0] q_in;
            logic                   dg_in, v_in, ge;
            logic [ACC_WIDTH:0]     diff;

            if (i == 0)
            begin : g_first
                assign trial  = {1'b0, in_data.num};
                assign den_in = in_data.den;
                assign q_in   = '0;
                assign dg_in  = in_data.degen;
                assign v_in   = in_valid;
            end
            else
            begin : g_next
                assign trial  = {rem_reg[i-1], 1'b0};
                assign den_in = den_reg[i-1];
                assign q_in   = q_reg[i-1];
                assign dg_in  = dg_reg[i-1];
                assign v_in   = v_reg[i-1];
            end

            assign ge   = trial >= {1'b0, den_in};
            assign diff = trial - {1'b0, den_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[i] <= ge ? diff[ACC_WIDTH-1:0] : trial[ACC_WIDTH-1:0];
                    den_reg[i] <= den_in;
                    dg_reg[i]  <= dg_in;
                    if (i == DIV_STEPS - 1)
                    begin
                        q_reg[i] <= q_in + RATIO_WIDTH'(ge);
                    end
                    else
                    begin
                        q_reg[i] <= {q_in[RATIO_WIDTH-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    assign out_valid              = v_reg[DIV_STEPS-1];
    assign out_data.overlap_ratio = q_reg[DIV_STEPS-1];
    assign out_data.degenerate    = dg_reg[DIV_STEPS-1];
endmodule

/* src/segment_projection_overlap.sv */
// Top level of the segment projection overlap block.
//
//   channel | direction | payload              | handshake
//   seg     | in        | seg_item_t, 8 coords | seg_valid / seg_ready
//   res     | out       | res_item_t           | res_valid / res_ready
//
// One transfer can enter every cycle while the pipeline is not held; each result passes through
// two front stages, two sum and clip stages and 17 divider stages, one quotient bit each but the last, which rounds.
// Reset clears only the valid bits of the stages.
// The whole pipeline moves as one; it holds when a result waits and res_ready is low,
// and bubbles are filled while the output stage is empty.
module segment_projection_overlap (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                seg_valid,
    output logic                seg_ready,
    input  spo_pkg::seg_item_t  seg,
    output logic                res_valid,
    input  logic                res_ready,
    output spo_pkg::res_item_t  res
);
    import spo_pkg::*;
    `include "segment_projection_overlap_macros.svh"

    logic   adv;
    logic   front_valid, norm_valid;
    prod_t  front_data;
    frac_t  norm_data;

    assign adv       = !res_valid || res_ready;
    assign seg_ready = adv;

    spo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (seg_valid),
        .in_data   (seg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    spo_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    spo_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .out_valid (res_valid),
        .out_data  (res)
    );

    `SPO_ASSERT_IMPL(a_degen_zero, res_valid && res.degenerate, res.overlap_ratio == '0, "degenerate result with nonzero ratio")
    `SPO_ASSERT_IMPL(a_ratio_max, res_valid, res.overlap_ratio <= RATIO_WIDTH'(1 << RATIO_FRAC_BITS), "ratio above one")
    `SPO_ASSERT_IMPL(a_hold, res_valid && !res_ready, ##1 res_valid && $stable(res), "stalled result changed")
endmodule

/* bench/segment_projection_overlap_tb.sv */
// Testbench for the segment projection overlap block, checked against a predictor.
class overlap_scoreboard;
    spo_pkg::res_item_t pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function spo_pkg::res_item_t predict(spo_pkg::seg_item_t s);
        spo_pkg::res_item_t r;
        longint dx, dy, n0, n1, d, lo, hi, num;
        longint q;
        dx = longint'(s.obs_end_x) - longint'(s.obs_start_x);
        dy = longint'(s.obs_end_y) - longint'(s.obs_start_y);
        r = '0;
        if (dx > -16 && dx < 16) begin
            if (dy == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            n0 = longint'(s.proj_start_y) - longint'(s.obs_start_y);
            n1 = longint'(s.proj_end_y) - longint'(s.obs_start_y);
            d = dy;
        end else if (dy > -16 && dy < 16) begin
            n0 = longint'(s.proj_start_x) - longint'(s.obs_start_x);
            n1 = longint'(s.proj_end_x) - longint'(s.obs_start_x);
            d = dx;
        end else begin
            n0 = (longint'(s.proj_start_x) - longint'(s.obs_start_x)) * dx
               + (longint'(s.proj_start_y) - longint'(s.obs_start_y)) * dy;
            n1 = (longint'(s.proj_end_x) - longint'(s.obs_start_x)) * dx
               + (longint'(s.proj_end_y) - longint'(s.obs_start_y)) * dy;
            d = dx * dx + dy * dy;
        end
        if (d < 0) begin
            d = -d;
            n0 = -n0;
            n1 = -n1;
        end
        lo = (n1 < n0) ? n1 : n0;
        hi = (n1 < n0) ? n0 : n1;
        lo = (lo < 0) ? 0 : ((lo > d) ? d : lo);
        hi = (hi < 0) ? 0 : ((hi > d) ? d : hi);
        num = hi - lo;
        q = ((num << 16) + d) / (2 * d);
        r.overlap_ratio = q[15:0];
        return r;
    endfunction

    function void note_transfer(spo_pkg::seg_item_t s);
        pending.insert(pending.size(), predict(s));
    endfunction

    function void check_result(spo_pkg::res_item_t r);
        spo_pkg::res_item_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result ratio=%0d degenerate=%0b",
                     $time, r.overlap_ratio, r.degenerate);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (r.overlap_ratio !== e.overlap_ratio) begin
            $display("%0t: overlap_ratio expected %0d actual %0d",
                     $time, e.overlap_ratio, r.overlap_ratio);
            errors++;
        end
        if (r.degenerate !== e.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b",
                     $time, e.degenerate, r.degenerate);
            errors++;
        end
    endfunction
endclass

module segment_projection_overlap_tb;
    import spo_pkg::*;

    logic clk;
    logic rst_n;
    logic seg_valid;
    logic seg_ready;
    seg_item_t seg;
    logic res_valid;
    logic res_ready;
    res_item_t res;

    overlap_scoreboard board;
    int send_idle;
    int recv_stall;
    bit recv_hold;

    segment_projection_overlap dut (
        .clk(clk),
        .rst_n(rst_n),
        .seg_valid(seg_valid),
        .seg_ready(seg_ready),
        .seg(seg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        board = new();
    end

    always @(posedge clk)
    begin
        if (rst_n && seg_valid && seg_ready)
            board.note_transfer(seg);
        if (rst_n && res_valid && res_ready)
            board.check_result(res);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (recv_hold)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic logic signed [15:0] coord(int spread);
        if (spread == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(2 * spread)) - spread);
    endfunction

    function automatic seg_item_t random_pair();
        seg_item_t s;
        int kind;
        int spread;
        kind = $urandom_range(9);
        spread = (kind < 3) ? 0 : ((kind < 6) ? 2000 : 300);
        s.obs_start_x = coord(spread);
        s.obs_start_y = coord(spread);
        s.obs_end_x = coord(spread);
        s.obs_end_y = coord(spread);
        s.proj_start_x = coord(spread);
        s.proj_start_y = coord(spread);
        s.proj_end_x = coord(spread);
        s.proj_end_y = coord(spread);
        case (kind)
            6: s.obs_end_x = s.obs_start_x + 16'(int'($urandom_range(30)) - 15);
            7: s.obs_end_y = s.obs_start_y + 16'(int'($urandom_range(30)) - 15);
            8:
            begin
                s.obs_end_x = s.obs_start_x + 16'(int'($urandom_range(30)) - 15);
                if ($urandom_range(1))
                    s.obs_end_y = s.obs_start_y;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_pair(seg_item_t s);
        while ($urandom_range(99) < send_idle)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg <= s;
        @(posedge clk);
        while (!seg_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_pair(output seg_item_t s,
                              input int ax, ay, bx, by, px, py, qx, qy);
        s.obs_start_x = 16'(ax);
        s.obs_start_y = 16'(ay);
        s.obs_end_x = 16'(bx);
        s.obs_end_y = 16'(by);
        s.proj_start_x = 16'(px);
        s.proj_start_y = 16'(py);
        s.proj_end_x = 16'(qx);
        s.proj_end_y = 16'(qy);
    endtask

    initial
    begin
        seg_item_t s;
        rst_n = 1'b0;
        seg_valid = 1'b0;
        seg = '0;
        send_idle = 0;
        recv_stall = 0;
        recv_hold = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_pair(s, 0, 0, 0, 0, 5, 5, 9, 9);
        send_pair(s);
        build_pair(s, 0, 0, 15, 0, 5, 5, 9, 9);
        send_pair(s);
        build_pair(s, 0, 0, 5, 160, 0, -40, 0, 80);
        send_pair(s);
        build_pair(s, 0, 160, -15, 0, 0, 0, 0, 320);
        send_pair(s);
        build_pair(s, 0, 0, 160, 5, -100, 0, 60, 0);
        send_pair(s);
        build_pair(s, 160, 0, 0, -15, 200, 0, -200, 0);
        send_pair(s);
        build_pair(s, 0, 0, 160, 160, 40, 40, 120, 120);
        send_pair(s);
        build_pair(s, 0, 0, 160, 160, 200, 200, 400, 400);
        send_pair(s);
        build_pair(s, 0, 0, 160, 160, -10, -10, -300, -300);
        send_pair(s);
        build_pair(s, 0, 0, 160, 480, 1, 1, 1, 1);
        send_pair(s);
        build_pair(s, 0, 0, 48, 0, 16, 0, 32, 0);
        send_pair(s);
        build_pair(s, -32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
        send_pair(s);
        build_pair(s, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_pair(s);
        build_pair(s, -32768, 0, 32767, 0, 32767, 0, -32768, 0);
        send_pair(s);
        build_pair(s, 0, 32767, 0, -32768, 0, -32768, 0, 32767);
        send_pair(s);
        build_pair(s, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
        send_pair(s);
        build_pair(s, -32768, -32768, -32752, -32752, 32767, 32767, -1, -1);
        send_pair(s);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 77 : 20) : 0;
            recv_stall = (phase == 2 || phase == 3) ? ((phase == 2) ? 77 : 20) : 0;
            for (int i = 0; i < 400; i++)
                send_pair(random_pair());
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        fork
            begin
                recv_hold <= 1'b1;
                repeat (200) @(posedge clk);
                recv_hold <= 1'b0;
            end
            for (int i = 0; i < 150; i++)
                send_pair(random_pair());
        join
        drain();
        repeat (40) @(posedge clk);

        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/spo_pkg.sv
src/spo_front.sv
src/spo_norm.sv
src/spo_div.sv
src/segment_projection_overlap.sv
bench/segment_projection_overlap_tb.sv
